// ===== rtl/oct_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helpers for the owner cookie table.
// Used by oct_cell_array, oct_decide and owner_cookie_table; depends on nothing.
package oct_pkg;

   localparam int ENTRIES    = 64;
   localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int KEY_W      = 22;
   localparam int COOKIE_W   = 64;
   localparam int STATUS_W   = 3;
   localparam int OUT_IDX_W  = 6;
   localparam int REQ_DATA_W = ((KEY_W + COOKIE_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((STATUS_W + OUT_IDX_W + 7) / 8) * 8;

   localparam logic KIND_LOOKUP = 1'b0;
   localparam logic KIND_DELETE = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_FOUND     = 3'd0,
      ST_INSERTED  = 3'd1,
      ST_DENIED    = 3'd2,
      ST_FULL      = 3'd3,
      ST_DELETED   = 3'd4,
      ST_NOT_FOUND = 3'd5
   } status_type;

   // Table write command: set loads key and cookie and marks valid, clr drops valid.
   typedef struct packed {
      logic             set;
      logic             clr;
      logic [IDX_W-1:0] idx;
   } slot_cmd_type;

   // Lowest set bit of a slot vector.
   function automatic logic [IDX_W-1:0] lowest_index(input logic [ENTRIES-1:0] vec);
      logic [IDX_W-1:0] idx;
      idx = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (vec[i]) begin
            idx = IDX_W'(i);
         end
      end
      return idx;
   endfunction

   // Low bits of a slot number, zero extended when the table is narrow.
   function automatic logic [OUT_IDX_W-1:0] out_index(input logic [IDX_W-1:0] idx);
      logic [IDX_W+OUT_IDX_W-1:0] wide;
      wide = {{OUT_IDX_W{1'b0}}, idx};
      return wide[OUT_IDX_W-1:0];
   endfunction

endpackage

// ===== rtl/owner_cookie_table.sv =====
`timescale 1ns / 1ps
// Owner cookie table top level: request register, cell row, outcome logic, result register.
// Depends on oct_pkg, oct_cell_array and oct_decide.
//
// Keeps 64 process slots, each a valid mark, a 22-bit process id and a 64-bit owner
// cookie. A lookup request (tuser 0) reports found with the slot when the id is present
// with the same cookie, access denied for a different cookie, otherwise writes id and
// cookie into the lowest free slot and reports inserted, or reports table full. A delete
// request (tuser 1) frees the matching slot and reports deleted, or reports not found.
// Every request gives exactly one response. A request is taken into an input register,
// compared against all slots at once and resolved, with the table updated at the edge
// that captures the result, so the next request sees the result of the previous one.
// The request waits in the request register and its outcome in the response register.
// Throughput is one request per cycle while the response is not stalled. The path that
// sets this is the parallel key and cookie compare over all slots followed by the
// lowest-slot priority encode. Valid marks clear on reset; no clearing pass is needed.
module owner_cookie_table (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [21:0] proc_id, [85:22] owner_cookie, [87:86] zero
   input  logic [oct_pkg::REQ_DATA_W-1:0]     req_tdata,
   // [0] kind
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [2:0] status, [8:3] entry_index, [15:9] zero
   output logic [oct_pkg::RSP_DATA_W-1:0]     rsp_tdata
);

   // Request register.
   logic                           in_valid_ff;
   logic                           in_valid_in;
   logic                           in_kind_ff;
   logic [oct_pkg::KEY_W-1:0]      in_key_ff;
   logic [oct_pkg::COOKIE_W-1:0]   in_cookie_ff;

   // Response register.
   logic                           out_valid_ff;
   logic                           out_valid_in;
   oct_pkg::status_type            out_status_ff;
   logic [oct_pkg::OUT_IDX_W-1:0]  out_index_ff;

   logic                           advance;
   logic                           req_take;
   logic [oct_pkg::ENTRIES-1:0]    hit_vec;
   logic [oct_pkg::ENTRIES-1:0]    ceq_vec;
   logic [oct_pkg::ENTRIES-1:0]    free_vec;
   oct_pkg::status_type            status_next;
   logic [oct_pkg::OUT_IDX_W-1:0]  index_next;
   oct_pkg::slot_cmd_type          cmd;

   // Resolve the held request when the response register is free or draining.
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Hold the request payload until it is resolved.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_kind_ff   <= req_tuser;
         in_key_ff    <= req_tdata[oct_pkg::KEY_W-1:0];
         in_cookie_ff <= req_tdata[oct_pkg::KEY_W+oct_pkg::COOKIE_W-1:oct_pkg::KEY_W];
      end
   end

   // Capture the outcome; the table write happens at the same edge.
   always_ff @(posedge clock) begin
      if (advance) begin
         out_status_ff <= status_next;
         out_index_ff  <= index_next;
      end
   end

   oct_cell_array u_cells (
      .clock    (clock),
      .reset    (reset),
      .key      (in_key_ff),
      .cookie   (in_cookie_ff),
      .cmd      (cmd),
      .hit_vec  (hit_vec),
      .ceq_vec  (ceq_vec),
      .free_vec (free_vec)
   );

   oct_decide u_decide (
      .active      (advance),
      .kind        (in_kind_ff),
      .hit_vec     (hit_vec),
      .ceq_vec     (ceq_vec),
      .free_vec    (free_vec),
      .status      (status_next),
      .entry_index (index_next),
      .cmd         (cmd)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(oct_pkg::RSP_DATA_W - oct_pkg::STATUS_W - oct_pkg::OUT_IDX_W){1'b0}},
                        out_index_ff, out_status_ff};

   // A slot write only ever sets or clears, never both.
   assert property (@(posedge clock) disable iff (reset) !(cmd.set && cmd.clr))
      else $error("slot set and clear in the same cycle");

   // An inserted slot is occupied on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      cmd.set |=> !free_vec[$past(cmd.idx)])
      else $error("inserted slot not marked valid");

   // Table full is reported only when no slot is free.
   assert property (@(posedge clock) disable iff (reset)
      (advance && status_next == oct_pkg::ST_FULL) |-> (free_vec == '0))
      else $error("table full reported with a free slot");

   // A resolved request always leaves a response pending on the next cycle.
   assert property (@(posedge clock) disable iff (reset) advance |=> out_valid_ff)
      else $error("resolved request lost its response");

endmodule

// ===== rtl/oct_cell_array.sv =====
`timescale 1ns / 1ps
// Row of table cells: valid mark, key and cookie per slot, with per-cell compare.
// Depends on oct_pkg.
module oct_cell_array (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [oct_pkg::KEY_W-1:0]     key,
   input  logic [oct_pkg::COOKIE_W-1:0]  cookie,
   input  oct_pkg::slot_cmd_type         cmd,
   output logic [oct_pkg::ENTRIES-1:0]   hit_vec,
   output logic [oct_pkg::ENTRIES-1:0]   ceq_vec,
   output logic [oct_pkg::ENTRIES-1:0]   free_vec
);

   logic [oct_pkg::ENTRIES-1:0]  valid_ff;
   logic [oct_pkg::ENTRIES-1:0]  valid_in;
   logic [oct_pkg::KEY_W-1:0]    key_ff    [oct_pkg::ENTRIES];
   logic [oct_pkg::COOKIE_W-1:0] cookie_ff [oct_pkg::ENTRIES];

   always_comb begin
      valid_in = valid_ff;
      if (cmd.set) begin
         valid_in[cmd.idx] = 1'b1;
      end
      if (cmd.clr) begin
         valid_in[cmd.idx] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.set) begin
         key_ff[cmd.idx]    <= key;
         cookie_ff[cmd.idx] <= cookie;
      end
   end

   // Compare every cell against the presented key and cookie.
   always_comb begin
      for (int i = 0; i < oct_pkg::ENTRIES; i++) begin
         hit_vec[i]  = valid_ff[i] && (key_ff[i] == key);
         ceq_vec[i]  = (cookie_ff[i] == cookie);
         free_vec[i] = !valid_ff[i];
      end
   end

endmodule

// ===== rtl/oct_decide.sv =====
`timescale 1ns / 1ps
// Outcome logic: encode hit and free slots, pick the status and the table write.
// Depends on oct_pkg.
module oct_decide (
   input  logic                               active,
   input  logic                               kind,
   input  logic [oct_pkg::ENTRIES-1:0]        hit_vec,
   input  logic [oct_pkg::ENTRIES-1:0]        ceq_vec,
   input  logic [oct_pkg::ENTRIES-1:0]        free_vec,
   output oct_pkg::status_type                status,
   output logic [oct_pkg::OUT_IDX_W-1:0]      entry_index,
   output oct_pkg::slot_cmd_type              cmd
);

   logic                      hit_any;
   logic                      free_any;
   logic [oct_pkg::IDX_W-1:0] hit_idx;
   logic [oct_pkg::IDX_W-1:0] free_idx;

   assign hit_any  = |hit_vec;
   assign free_any = |free_vec;
   assign hit_idx  = oct_pkg::lowest_index(hit_vec);
   assign free_idx = oct_pkg::lowest_index(free_vec);

   always_comb begin
      status      = oct_pkg::ST_NOT_FOUND;
      entry_index = '0;
      cmd.set     = 1'b0;
      cmd.clr     = 1'b0;
      cmd.idx     = hit_idx;
      case (kind)
         oct_pkg::KIND_LOOKUP: begin
            if (hit_any) begin
               if (ceq_vec[hit_idx]) begin
                  status      = oct_pkg::ST_FOUND;
                  entry_index = oct_pkg::out_index(hit_idx);
               end else begin
                  status = oct_pkg::ST_DENIED;
               end
            end else if (free_any) begin
               status      = oct_pkg::ST_INSERTED;
               entry_index = oct_pkg::out_index(free_idx);
               cmd.set     = active;
               cmd.idx     = free_idx;
            end else begin
               status = oct_pkg::ST_FULL;
            end
         end
         oct_pkg::KIND_DELETE: begin
            if (hit_any) begin
               status      = oct_pkg::ST_DELETED;
               entry_index = oct_pkg::out_index(hit_idx);
               cmd.clr     = active;
            end
         end
         default: begin
            status = oct_pkg::ST_NOT_FOUND;
         end
      endcase
   end

endmodule
